>>> design/first_unique_symbol_tracker_core_defines.svh
// assertion macros shared by the first-unique-symbol tracker modules
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_CORE_DEFINES_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define FUST_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fust same-cycle check failed");

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define FUST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fust next-cycle check failed");

`endif

>>> design/fust_pkg.sv
// types and constants for the first-unique-symbol tracker
package fust_pkg;

    localparam int SYM_W             = 5;
    localparam int DEF_ALPHABET_SIZE = 26;

    typedef logic [SYM_W-1:0] sym_t;

    // link value meaning "no symbol"
    localparam sym_t NULL_CODE = 5'd31;

    // saturating sighting count
    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONCE = 2'd1,
        CNT_MANY = 2'd2
    } cnt_t;

    typedef struct packed {
        sym_t symbol;
        logic new_sequence;
    } item_t;

    typedef struct packed {
        logic found;
        sym_t first_unique;
    } result_t;

endpackage

>>> design/fust_stream_ifs.sv
// valid/ready channel interfaces for symbols in and results out
interface fust_sym_if import fust_pkg::*; ();
    logic valid;
    logic ready;
    sym_t symbol;
    logic new_sequence;

    modport source (output valid, output symbol, output new_sequence, input ready);
    modport sink   (input valid, input symbol, input new_sequence, output ready);
endinterface

interface fust_res_if import fust_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    sym_t first_unique;

    modport source (output valid, output found, output first_unique, input ready);
    modport sink   (input valid, input found, input first_unique, output ready);
endinterface

>>> design/fust_in_reg.sv
// input register stage holding one accepted symbol transaction
module fust_in_reg import fust_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fust_sym_if.sink   sym,
    input  logic       advance,
    output logic       valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // free when empty or when the held item moves on this cycle
    assign sym.ready = !valid_reg || advance;
    assign accept    = sym.valid && sym.ready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.symbol       <= sym.symbol;
            item_reg.new_sequence <= sym.new_sequence;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> design/fust_list.sv
// sighting counts and ordered list of once-seen symbols, updated one item per cycle while commit is high
`include "first_unique_symbol_tracker_core_defines.svh"

module fust_list import fust_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  commit,
    input  item_t item,
    output sym_t  head_next
);

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    cnt_t cnt_reg  [ALPHABET_SIZE];
    cnt_t cnt_next [ALPHABET_SIZE];
    sym_t prev_reg [ALPHABET_SIZE];
    sym_t prev_next[ALPHABET_SIZE];
    sym_t next_reg [ALPHABET_SIZE];
    sym_t next_next[ALPHABET_SIZE];
    sym_t head_reg;
    sym_t tail_reg;
    sym_t tail_next;

    logic             in_range;
    logic [IDX_W-1:0] sidx;
    cnt_t             cnt_cur;
    sym_t             p_cur;
    sym_t             n_cur;
    sym_t             head_eff;
    sym_t             tail_eff;
    logic             do_append;
    logic             do_unlink;
    logic [IDX_W-1:0] head_idx;

    // look up the incoming symbol, with a sequence restart seen as a clear
    always_comb
    begin
        in_range  = item.symbol < SYM_W'(ALPHABET_SIZE);
        sidx      = item.symbol[IDX_W-1:0];
        cnt_cur   = item.new_sequence ? CNT_NONE : cnt_reg[sidx];
        p_cur     = prev_reg[sidx];
        n_cur     = next_reg[sidx];
        head_eff  = item.new_sequence ? NULL_CODE : head_reg;
        tail_eff  = item.new_sequence ? NULL_CODE : tail_reg;
        do_append = in_range && (cnt_cur == CNT_NONE);
        do_unlink = in_range && (cnt_cur == CNT_ONCE);
    end

    // per-entry next state: append at tail or unlink from the list
    always_comb
    begin
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            cnt_next[i]  = item.new_sequence ? CNT_NONE  : cnt_reg[i];
            prev_next[i] = item.new_sequence ? NULL_CODE : prev_reg[i];
            next_next[i] = item.new_sequence ? NULL_CODE : next_reg[i];

            if (do_append && item.symbol == SYM_W'(i))
            begin
                cnt_next[i]  = CNT_ONCE;
                prev_next[i] = tail_eff;
                next_next[i] = NULL_CODE;
            end
            if (do_append && tail_eff == SYM_W'(i))
            begin
                next_next[i] = item.symbol;
            end

            if (do_unlink && item.symbol == SYM_W'(i))
            begin
                cnt_next[i]  = CNT_MANY;
                prev_next[i] = NULL_CODE;
                next_next[i] = NULL_CODE;
            end
            if (do_unlink && p_cur == SYM_W'(i))
            begin
                next_next[i] = n_cur;
            end
            if (do_unlink && n_cur == SYM_W'(i))
            begin
                prev_next[i] = p_cur;
            end
        end
    end

    // head and tail next state
    always_comb
    begin
        head_next = head_eff;
        tail_next = tail_eff;
        if (do_append)
        begin
            if (tail_eff == NULL_CODE)
            begin
                head_next = item.symbol;
            end
            tail_next = item.symbol;
        end
        else if (do_unlink)
        begin
            if (p_cur == NULL_CODE)
            begin
                head_next = n_cur;
            end
            if (n_cur == NULL_CODE)
            begin
                tail_next = p_cur;
            end
        end
    end

    // state registers, written when an item completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                cnt_reg[i]  <= CNT_NONE;
                prev_reg[i] <= NULL_CODE;
                next_reg[i] <= NULL_CODE;
            end
            head_reg <= NULL_CODE;
            tail_reg <= NULL_CODE;
        end
        else if (commit)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                cnt_reg[i]  <= cnt_next[i];
                prev_reg[i] <= prev_next[i];
                next_reg[i] <= next_next[i];
            end
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assign head_idx = head_reg[IDX_W-1:0];

    // list consistency checks
    `FUST_ASSERT_NOW(a_head_tail_null, 1'b1, (head_reg == NULL_CODE) == (tail_reg == NULL_CODE))
    `FUST_ASSERT_NOW(a_head_seen_once, head_reg != NULL_CODE, cnt_reg[head_idx] == CNT_ONCE)
    `FUST_ASSERT_NOW(a_head_no_prev, head_reg != NULL_CODE, prev_reg[head_idx] == NULL_CODE)

endmodule

>>> design/first_unique_symbol_tracker_core.sv
// top level of the first-unique-symbol tracker
// One symbol transaction is taken per clock unless the result side stalls, and one result
// transaction comes out for each, in order. The input register feeds the count/list update,
// whose new list head is captured in the result register when the held item commits, so a
// result passes through the input register and then the result register; the sustained rate
// is one item per cycle when the result side is not stalled. A stalled result register holds
// while the input register still takes one more symbol. new_sequence clears all counts and
// the list before its own symbol is handled; symbols at or above ALPHABET_SIZE leave the
// state alone and just report the current earliest once-seen symbol.
`include "first_unique_symbol_tracker_core_defines.svh"

module first_unique_symbol_tracker_core import fust_pkg::*;
#(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
)
(
    input  logic       clk,
    input  logic       rst_n,
    fust_sym_if.sink   sym,
    fust_res_if.source res
);

    logic    s1_valid;
    item_t   s1_item;
    logic    advance;
    logic    commit;
    sym_t    head_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // the held item moves on when the result register is free or being drained
    assign advance = !out_valid_reg || res.ready;
    assign commit  = s1_valid && advance;

    fust_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .sym     (sym),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    fust_list #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item      (s1_item),
        .head_next (head_next)
    );

    // result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result capture from the updated list head
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg.found        <= (head_next != NULL_CODE);
            res_reg.first_unique <= (head_next != NULL_CODE) ? head_next : '0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.found        = res_reg.found;
    assign res.first_unique = res_reg.first_unique;

    // result path checks
    `FUST_ASSERT_NEXT(a_commit_gives_result, commit, res.valid)
    `FUST_ASSERT_NEXT(a_res_held, res.valid && !res.ready, res.valid)
    `FUST_ASSERT_NOW(a_empty_reports_zero, res.valid && !res.found, res.first_unique == '0)

endmodule

>>> tb/tb.sv
// self-checking testbench for the first-unique-symbol tracker core

// predicts the earliest once-seen symbol and checks each result transaction in order
class first_unique_scoreboard;
    fust_pkg::cnt_t    seen[32];
    fust_pkg::sym_t    prv[32];
    fust_pkg::sym_t    nxt[32];
    fust_pkg::sym_t    head;
    fust_pkg::sym_t    tail;
    fust_pkg::result_t expected_q[$];
    int unsigned       alphabet;
    int                errors;

    function new(int unsigned alphabet_size);
        alphabet = alphabet_size;
        errors   = 0;
        wipe();
    endfunction

    // empty counts and the once-seen list
    function void wipe();
        foreach (seen[i])
        begin
            seen[i] = fust_pkg::CNT_NONE;
            prv[i]  = fust_pkg::NULL_CODE;
            nxt[i]  = fust_pkg::NULL_CODE;
        end
        head = fust_pkg::NULL_CODE;
        tail = fust_pkg::NULL_CODE;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function int pending();
        return expected_q.size();
    endfunction

    // update the list for an accepted symbol and queue the head it leaves
    function void note_item(fust_pkg::item_t it);
        fust_pkg::sym_t    s;
        fust_pkg::sym_t    p;
        fust_pkg::sym_t    n;
        fust_pkg::result_t exp_res;
        s = it.symbol;
        if (it.new_sequence)
            wipe();
        if (s < alphabet)
        begin
            case (seen[s])
                fust_pkg::CNT_NONE:
                begin
                    // first sighting goes on the tail
                    seen[s] = fust_pkg::CNT_ONCE;
                    prv[s]  = tail;
                    nxt[s]  = fust_pkg::NULL_CODE;
                    if (tail == fust_pkg::NULL_CODE)
                        head = s;
                    else
                        nxt[tail] = s;
                    tail = s;
                end
                fust_pkg::CNT_ONCE:
                begin
                    // second sighting drops out of the list
                    seen[s] = fust_pkg::CNT_MANY;
                    p = prv[s];
                    n = nxt[s];
                    if (p == fust_pkg::NULL_CODE)
                        head = n;
                    else
                        nxt[p] = n;
                    if (n == fust_pkg::NULL_CODE)
                        tail = p;
                    else
                        prv[n] = p;
                    prv[s] = fust_pkg::NULL_CODE;
                    nxt[s] = fust_pkg::NULL_CODE;
                end
                default: ;
            endcase
        end
        exp_res.found        = (head != fust_pkg::NULL_CODE);
        exp_res.first_unique = exp_res.found ? head : '0;
        expected_q.push_back(exp_res);
    endfunction

    // compare one result transaction with the oldest expectation
    task check_result(fust_pkg::result_t got);
        fust_pkg::result_t exp_res;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result found=%0d first_unique=%0d with nothing outstanding",
                             got.found, got.first_unique));
        end
        else
        begin
            exp_res = expected_q.pop_front();
            if (got.found !== exp_res.found)
                report($sformatf("found got %0d exp %0d", got.found, exp_res.found));
            if (got.first_unique !== exp_res.first_unique)
                report($sformatf("first_unique got %0d exp %0d",
                                 got.first_unique, exp_res.first_unique));
        end
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fust_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    fust_sym_if sym_ch ();
    fust_res_if res_ch ();

    first_unique_symbol_tracker_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym_ch),
        .res   (res_ch)
    );

    first_unique_scoreboard sb;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycles;
    logic        long_hold_req;
    int unsigned hold_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** first_unique_symbol_tracker_core: FAILED **");
        $finish;
    end

    // result side: check each transaction, then pick next ready
    initial
    begin
        res_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result('{found: res_ch.found, first_unique: res_ch.first_unique});
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one symbol transaction and wait until it is taken
    task automatic send_item(logic [4:0] symbol, logic new_sequence);
        item_t it;
        it.symbol       = symbol;
        it.new_sequence = new_sequence;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sym_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sym_ch.valid        <= 1'b1;
        sym_ch.symbol       <= it.symbol;
        sym_ch.new_sequence <= it.new_sequence;
        do
            @(posedge clk);
        while (!sym_ch.ready);
        sb.note_item(it);
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain();
        sym_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed sequences with random content, some loose noise
    task automatic random_items(int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned span;
        int unsigned base;
        logic [4:0]  s;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                len  = $urandom_range(1, 40);
                span = $urandom_range(2, 26);
                base = $urandom_range(0, 26 - span);
                for (int unsigned k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < 8)
                        s = 5'($urandom_range(26, 31));
                    else
                        s = 5'(base + $urandom_range(0, span - 1));
                    send_item(s, k == 0);
                end
                sent += len;
            end
            else
            begin
                send_item(5'($urandom_range(0, 31)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // stimulus
    initial
    begin
        sb = new(DEF_ALPHABET_SIZE);
        long_hold_req = 1'b0;
        send_idle_pct  = 18;
        recv_stall_pct = 50;
        rst_n = 1'b0;
        sym_ch.valid        <= 1'b0;
        sym_ch.symbol       <= '0;
        sym_ch.new_sequence <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: empty list, head/middle/tail removal, saturation, out of range, clears
        send_item(5'd31, 1'b0);
        send_item(5'd0, 1'b0);
        send_item(5'd25, 1'b0);
        send_item(5'd12, 1'b0);
        send_item(5'd0, 1'b0);
        send_item(5'd12, 1'b0);
        send_item(5'd0, 1'b0);
        send_item(5'd26, 1'b0);
        send_item(5'd7, 1'b0);
        send_item(5'd3, 1'b0);
        send_item(5'd7, 1'b0);
        send_item(5'd25, 1'b0);
        send_item(5'd3, 1'b0);
        send_item(5'd30, 1'b1);
        send_item(5'd0, 1'b1);
        send_item(5'd0, 1'b0);
        send_item(5'd16, 1'b0);
        send_item(5'd15, 1'b0);
        send_item(5'd5, 1'b1);
        send_item(5'd31, 1'b1);
        send_item(5'd1, 1'b0);
        send_item(5'd2, 1'b0);
        send_item(5'd4, 1'b0);
        send_item(5'd8, 1'b0);
        random_items(200);

        // sender pauses until everything is back
        drain();
        repeat (5) @(posedge clk);

        send_idle_pct  = 50;
        recv_stall_pct = 18;
        random_items(230);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_items(100);

        // receiver holds off while symbols keep coming, so the input stalls
        long_hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_item(5'($urandom_range(0, 31)), k == 0);
        random_items(130);

        drain();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("** first_unique_symbol_tracker_core: PASSED **");
        else
            $display("** first_unique_symbol_tracker_core: FAILED **");
        $finish;
    end
endmodule
